>>> rtl/pba_pkg.sv
// Shared constants, types and helper functions of the page bitmap allocator.
`timescale 1ns / 1ps

package pba_pkg;

    // Bitmap geometry: one word holds 32 pages.
    localparam int MapWords  = 1024;
    localparam int WordAddrW = 10;
    localparam int PageW     = 15;
    localparam int CountW    = 16;

    localparam logic [WordAddrW-1:0] LastWord      = WordAddrW'(MapWords - 1);
    localparam logic [16:0]          TotalPages    = 17'(MapWords * 32);
    localparam logic [15:0]          DmaLimitReset = 16'd4096;
    localparam logic [31:0]          AllOnes       = 32'hffff_ffff;

    // Command codes.
    typedef enum logic [2:0] {
        OP_MARK_FREE   = 3'd0,
        OP_MARK_USED   = 3'd1,
        OP_CHECK       = 3'd2,
        OP_ALLOC_PAGE  = 3'd3,
        OP_ALLOC_RANGE = 3'd4,
        OP_ALLOC_DMA   = 3'd5,
        OP_COUNT       = 3'd6,
        OP_NOP         = 3'd7
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_ZERO_COUNT = 2'd1,
        STS_OVERRUN    = 2'd2,
        STS_NO_MEMORY  = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MRD,
        ST_MWR,
        ST_APW,
        ST_DONE
    } t_state;

    // Outcome of examining one bitmap word during a run search.
    typedef struct packed {
        logic                found;
        logic [PageW-1:0]    begin_pg;
        logic [CountW-1:0]   run;
        logic [PageW-1:0]    run_begin;
    } t_run_res;

    // Number of set bits in a word, summed as an adder tree.
    function automatic logic [5:0] popcount32(input logic [31:0] x);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    // Ones from bit lo up to and including bit hi.
    function automatic logic [31:0] range_mask(input logic [4:0] lo, input logic [4:0] hi);
        return (AllOnes << lo) & (AllOnes >> (5'd31 - hi));
    endfunction

    // Position of the lowest set bit; zero when the word is empty.
    function automatic logic [4:0] lowest_set(input logic [31:0] x);
        logic [4:0] pos;
        pos = '0;
        for (int b = 31; b >= 0; b--) begin
            if (x[b]) pos = 5'(b);
        end
        return pos;
    endfunction

endpackage

>>> rtl/pba_if.sv
// Handshake channel interfaces for commands, results and configuration writes.
`timescale 1ns / 1ps

interface pba_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [14:0] page_index;
    logic [15:0] count;
    logic [14:0] floor_page;

    modport source (output valid, opcode, page_index, count, floor_page, input ready);
    modport sink   (input valid, opcode, page_index, count, floor_page, output ready);
endinterface

interface pba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] result_page;
    logic        all_free;
    logic [15:0] free_count;

    modport source (output valid, status, result_page, all_free, free_count, input ready);
    modport sink   (input valid, status, result_page, all_free, free_count, output ready);
endinterface

interface pba_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] dma_limit_page;

    modport source (output valid, dma_limit_page, input ready);
    modport sink   (input valid, dma_limit_page, output ready);
endinterface

>>> rtl/pba_run_scan.sv
// Examines one bitmap word for a run of free pages, carrying a run across words.
`timescale 1ns / 1ps

module pba_run_scan (
    input  logic [31:0]                    i_word,
    input  logic [pba_pkg::WordAddrW-1:0]  i_word_idx,
    input  logic [pba_pkg::CountW-1:0]     i_run,
    input  logic [pba_pkg::PageW-1:0]      i_run_begin,
    input  logic [pba_pkg::CountW-1:0]     i_num,
    output pba_pkg::t_run_res              o_res
);
    import pba_pkg::*;

    logic [5:0]        trail_ones;
    logic [5:0]        lead_ones;
    logic [PageW-1:0]  base_pg;
    logic [PageW-1:0]  cont_begin;
    logic              cont_ok;
    logic              num_small;
    logic [31:0]       run_mask;
    logic [31:0]       fits;
    logic [4:0]        first_fit;

    // Trailing and leading runs of ones in the word.
    always_comb begin
        trail_ones = 6'd32;
        lead_ones  = 6'd32;
        for (int b = 31; b >= 0; b--) begin
            if (!i_word[b]) trail_ones = 6'(b);
        end
        for (int b = 0; b < 32; b++) begin
            if (!i_word[b]) lead_ones = 6'(31 - b);
        end
    end

    assign base_pg    = {i_word_idx, 5'd0};
    assign cont_begin = (i_run == '0) ? base_pg : i_run_begin;
    assign cont_ok    = ({1'b0, i_run} + 17'(trail_ones)) >= {1'b0, i_num};

    // A run that lies wholly inside this word, tried at every start bit.
    assign num_small = (i_num <= 16'd32);
    assign run_mask  = AllOnes >> (6'd32 - i_num[5:0]);

    always_comb begin
        for (int s = 0; s < 32; s++) begin
            fits[s] = num_small && ((7'(s) + i_num[6:0]) <= 7'd32) &&
                      (((i_word >> s) & run_mask) == run_mask);
        end
        first_fit = lowest_set(fits);
    end

    // A run continuing from earlier words always completes before one inside the word.
    always_comb begin
        o_res.found    = cont_ok || (fits != '0);
        o_res.begin_pg = cont_ok ? cont_begin : (base_pg + 15'(first_fit));
        if (i_word == AllOnes) begin
            o_res.run       = i_run + 16'd32;
            o_res.run_begin = cont_begin;
        end else begin
            o_res.run       = 16'(lead_ones);
            o_res.run_begin = base_pg + 15'(6'd32 - lead_ones);
        end
    end

endmodule

>>> rtl/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator: sequencer, bitmap memory and result register.
`timescale 1ns / 1ps
// Flow: an error or no-op goes straight to its result; a mark of W words reads, then
// writes back, each word in turn; a check, count or search reads N words, one per cycle
// (N up to 1024); a found page adds a write-back of its word, a found run its mark pass.
// One command is in work at a time; the next can be taken in the cycle after its result
// loads, also while that result waits. Reset: a clearing pass marks every page used;
// commands wait for it, configuration writes do not. The DMA limit resets to page 4096.

module page_bitmap_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pba_cmd_if.sink    i_cmd,
    pba_rsp_if.source  o_rsp,
    pba_cfg_if.sink    i_cfg
);
    import pba_pkg::*;

    // Bitmap storage, 1 means free.
    logic [31:0] r_bitmap [MapWords];
    logic [31:0] r_rdata;

    t_state                r_state, n_state;
    logic [WordAddrW-1:0]  r_clr_addr;
    logic [15:0]           r_dma;

    // Command in work.
    t_op                   r_op;
    logic [CountW-1:0]     r_num;
    logic                  r_mark_free;
    logic [PageW-1:0]      r_first_pg;
    logic [PageW-1:0]      r_last_pg;
    logic [4:0]            r_lim_bit;
    logic                  r_first;

    // Scan pipeline: read issue address and the word now in r_rdata.
    logic                  r_issue;
    logic [WordAddrW-1:0]  r_raddr;
    logic [WordAddrW-1:0]  r_end;
    logic                  r_vld;
    logic [WordAddrW-1:0]  r_dw;
    logic [WordAddrW-1:0]  r_mw;
    logic [31:0]           r_wdata;
    logic [CountW-1:0]     r_run;
    logic [PageW-1:0]      r_run_begin;

    // Working result.
    t_status               r_status;
    logic [PageW-1:0]      r_page;
    logic                  r_all;
    logic [CountW-1:0]     r_cnt;

    // Result register.
    logic                  r_rsp_valid;
    t_status               r_rsp_status;
    logic [PageW-1:0]      r_rsp_page;
    logic                  r_rsp_all;
    logic [CountW-1:0]     r_rsp_cnt;

    logic                  cmd_xfer;
    logic                  rsp_load;
    logic                  mem_re;
    logic [WordAddrW-1:0]  mem_raddr;
    logic                  mem_we;
    logic [WordAddrW-1:0]  mem_waddr;
    logic [31:0]           mem_wdata;

    // Command decode.
    t_op                   dec_op;
    t_state                dec_state;
    t_status               dec_status;
    logic [16:0]           dec_sum;
    logic [PageW-1:0]      dec_last;
    logic                  dec_zero;
    logic                  dec_over;

    // Per-word evaluation.
    logic [WordAddrW-1:0]  mask_w;
    logic [31:0]           word_mask;
    logic [31:0]           page_bits;
    logic [4:0]            page_bit;
    logic                  run_dma_bad;
    logic [16:0]           run_end;
    t_state                scan_state;
    t_run_res              run_res;

    pba_run_scan u_run_scan (
        .i_word      (r_rdata),
        .i_word_idx  (r_dw),
        .i_run       (r_run),
        .i_run_begin (r_run_begin),
        .i_num       (r_num),
        .o_res       (run_res)
    );

    assign cmd_xfer = i_cmd.valid && i_cmd.ready;
    assign rsp_load = (r_state == ST_DONE) && (!r_rsp_valid || o_rsp.ready);

    // Decode of an incoming command.
    always_comb begin
        dec_op     = t_op'(i_cmd.opcode);
        dec_zero   = (i_cmd.count == '0);
        dec_sum    = {2'b00, i_cmd.page_index} + {1'b0, i_cmd.count};
        dec_last   = dec_sum[14:0] - 15'd1;
        dec_over   = (dec_sum > TotalPages);
        dec_status = STS_OK;
        dec_state  = ST_DONE;
        unique case (dec_op)
            OP_MARK_FREE, OP_MARK_USED, OP_CHECK: begin
                if (dec_zero) begin
                    dec_status = STS_ZERO_COUNT;
                end else if (dec_over) begin
                    dec_status = STS_OVERRUN;
                end else begin
                    dec_state = (dec_op == OP_CHECK) ? ST_SCAN : ST_MRD;
                end
            end
            OP_ALLOC_PAGE, OP_COUNT: begin
                dec_state = ST_SCAN;
            end
            OP_ALLOC_RANGE: begin
                if (dec_zero) begin
                    dec_status = STS_ZERO_COUNT;
                end else if (r_dma[15]) begin
                    dec_status = STS_NO_MEMORY;
                end else begin
                    dec_state = ST_SCAN;
                end
            end
            OP_ALLOC_DMA: begin
                if (dec_zero) begin
                    dec_status = STS_ZERO_COUNT;
                end else begin
                    dec_state = ST_SCAN;
                end
            end
            OP_NOP: begin
                dec_state = ST_DONE;
            end
            default: begin
                dec_state = ST_DONE;
            end
        endcase
    end

    // Evaluation of the word that the scan has just read.
    always_comb begin
        mask_w    = (r_state == ST_MWR) ? r_mw : r_dw;
        word_mask = range_mask((mask_w == r_first_pg[14:5]) ? r_first_pg[4:0] : 5'd0,
                               (mask_w == r_last_pg[14:5])  ? r_last_pg[4:0]  : 5'd31);
        page_bits = r_rdata & (r_first ? (AllOnes << r_lim_bit) : AllOnes);
        page_bit  = lowest_set(page_bits);
        run_dma_bad = (r_op == OP_ALLOC_DMA) && ({1'b0, run_res.begin_pg} >= r_dma);
        run_end   = {2'b00, run_res.begin_pg} + {1'b0, r_num} - 17'd1;
        scan_state = ST_SCAN;
        unique case (r_op)
            OP_ALLOC_PAGE: begin
                if (page_bits != '0) begin
                    scan_state = ST_APW;
                end else if (r_dw == r_end) begin
                    scan_state = ST_DONE;
                end
            end
            OP_ALLOC_RANGE, OP_ALLOC_DMA: begin
                if (run_res.found) begin
                    scan_state = run_dma_bad ? ST_DONE : ST_MRD;
                end else if (r_dw == r_end) begin
                    scan_state = ST_DONE;
                end
            end
            OP_CHECK, OP_COUNT: begin
                if (r_dw == r_end) scan_state = ST_DONE;
            end
            default: begin
                scan_state = ST_DONE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == LastWord) n_state = ST_IDLE;
            ST_IDLE:  if (i_cmd.valid) n_state = dec_state;
            ST_SCAN:  if (r_vld) n_state = scan_state;
            ST_MRD:   n_state = ST_MWR;
            ST_MWR:   n_state = (r_mw == r_last_pg[14:5]) ? ST_DONE : ST_MRD;
            ST_APW:   n_state = ST_DONE;
            ST_DONE:  if (rsp_load) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State outputs: handshake and memory port controls.
    always_comb begin
        i_cmd.ready = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_raddr;
        mem_we      = 1'b0;
        mem_waddr   = r_mw;
        mem_wdata   = r_wdata;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            ST_SCAN: begin
                mem_re = r_issue;
            end
            ST_MRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_mw;
            end
            ST_MWR: begin
                mem_we    = 1'b1;
                mem_wdata = r_mark_free ? (r_rdata | word_mask) : (r_rdata & ~word_mask);
            end
            ST_APW: begin
                mem_we = 1'b1;
            end
            ST_DONE: begin
                i_cmd.ready = 1'b0;
            end
            default: begin
                i_cmd.ready = 1'b0;
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_bitmap[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_bitmap[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_dma       <= DmaLimitReset;
            r_issue     <= 1'b0;
            r_vld       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg.valid && i_cfg.ready) r_dma <= i_cfg.dma_limit_page;
            if (cmd_xfer) begin
                r_issue <= 1'b1;
                r_vld   <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_vld <= r_issue;
                if (r_issue) r_issue <= (r_raddr != r_end);
            end else begin
                r_vld <= 1'b0;
            end
            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_op        <= dec_op;
            r_num       <= i_cmd.count;
            r_mark_free <= (dec_op == OP_MARK_FREE);
            r_first_pg  <= i_cmd.page_index;
            r_last_pg   <= dec_last;
            r_lim_bit   <= i_cmd.floor_page[4:0];
            r_first     <= (dec_op == OP_ALLOC_PAGE);
            r_mw        <= i_cmd.page_index[14:5];
            r_run       <= '0;
            r_run_begin <= '0;
            r_status    <= dec_status;
            r_page      <= '0;
            r_all       <= (dec_op == OP_CHECK) && (dec_status == STS_OK);
            r_cnt       <= '0;
            unique case (dec_op)
                OP_CHECK: begin
                    r_raddr <= i_cmd.page_index[14:5];
                    r_end   <= dec_last[14:5];
                end
                OP_ALLOC_PAGE: begin
                    r_raddr <= i_cmd.floor_page[14:5];
                    r_end   <= LastWord;
                end
                OP_ALLOC_RANGE: begin
                    r_raddr <= r_dma[14:5];
                    r_end   <= LastWord;
                end
                default: begin
                    r_raddr <= '0;
                    r_end   <= LastWord;
                end
            endcase
        end else if (r_state == ST_SCAN) begin
            if (r_issue) begin
                r_raddr <= r_raddr + 1'b1;
                r_dw    <= r_raddr;
            end
            if (r_vld) begin
                r_first <= 1'b0;
                unique case (r_op)
                    OP_CHECK: begin
                        if ((r_rdata | ~word_mask) != AllOnes) r_all <= 1'b0;
                    end
                    OP_COUNT: begin
                        r_cnt <= r_cnt + 16'(popcount32(r_rdata));
                    end
                    OP_ALLOC_PAGE: begin
                        if (page_bits != '0) begin
                            r_page  <= {r_dw, page_bit};
                            r_mw    <= r_dw;
                            r_wdata <= r_rdata & ~(32'd1 << page_bit);
                        end else if (r_dw == r_end) begin
                            r_status <= STS_NO_MEMORY;
                        end
                    end
                    OP_ALLOC_RANGE, OP_ALLOC_DMA: begin
                        r_run       <= run_res.run;
                        r_run_begin <= run_res.run_begin;
                        if (run_res.found) begin
                            if (run_dma_bad) begin
                                r_status <= STS_NO_MEMORY;
                            end else begin
                                r_page     <= run_res.begin_pg;
                                r_first_pg <= run_res.begin_pg;
                                r_last_pg  <= run_end[14:0];
                                r_mw       <= run_res.begin_pg[14:5];
                            end
                        end else if (r_dw == r_end) begin
                            r_status <= STS_NO_MEMORY;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_state == ST_MWR) begin
            r_mw <= r_mw + 1'b1;
        end
        if (rsp_load) begin
            r_rsp_status <= r_status;
            r_rsp_page   <= r_page;
            r_rsp_all    <= r_all;
            r_rsp_cnt    <= r_cnt;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp_status;
    assign o_rsp.result_page = r_rsp_page;
    assign o_rsp.all_free    = r_rsp_all;
    assign o_rsp.free_count  = r_rsp_cnt;

    // A scan only reads; the bitmap is not written while one is in progress.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !mem_we)
        else $error("bitmap written during a scan");

    // Loading a result returns the sequencer to idle with the result shown.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_load |=> (r_state == ST_IDLE) && r_rsp_valid)
        else $error("result load did not return to idle");

    // A failed command reports no page and no free answer.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_rsp_status != STS_OK)) |-> (r_rsp_page == '0) && !r_rsp_all)
        else $error("error result carries a page or a free answer");

endmodule
